// ===== hw/rtl/psts_pkg.sv =====
// Shared widths, codes and defaults for the sorted-table search engine.
package psts_pkg;

    localparam int DATA_W              = 32;
    localparam int IDX_W               = 10;
    localparam int POS_W               = 11;
    localparam int COUNT_W             = 11;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 11;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_CHECK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_PRUNING    = 2'd2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 11'd1;

endpackage

// ===== hw/rtl/pruned_sorted_table_search_top.sv =====
// Sorted-table search engine: table RAM, probe sequencer and result register.
// A load item gives no result. A search runs the boundary pre-check when it is enabled
// (first-entry read, last-entry read, narrowing), then probes, each an address issue and
// a compare on the registered RAM data, at most about log2(entry_count)+1 of them, and
// then closes the range and registers the result.
// Throughput: one search at a time; loads are taken on consecutive cycles while idle.
// Reset: aresetn is synchronous, active low; entry_count returns to 1 and both prunings
// are disabled. Table contents are undefined until loaded; there is no clearing pass.
module pruned_sorted_table_search_top
    import psts_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic signed [DATA_W-1:0] s_value,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [POS_W-1:0]      m_position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = AW + 2;
    localparam int XW = (IW > COUNT_W + 1) ? IW : COUNT_W + 1;
    localparam int DW = DATA_W + 1;
    localparam logic signed [IW-1:0] IDX_ONE = IW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE_FIRST,
        S_PRE_LAST,
        S_PRE_NARROW,
        S_PROBE,
        S_COMPARE,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       entry_count_reg, entry_count_next;
    logic                     precheck_reg, precheck_next;
    logic                     gap_prune_reg, gap_prune_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [IW-1:0]     lo_reg, lo_next;
    logic signed [IW-1:0]     hi_reg, hi_next;
    logic signed [IW-1:0]     mid_reg, mid_next;
    logic                     pend_en_reg, pend_en_next;
    logic signed [IW-1:0]     pend_hi_reg, pend_hi_next;
    logic                     res_found_reg, res_found_next;
    logic signed [IW-1:0]     res_pos_reg, res_pos_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_found_reg, m_found_next;
    logic [POS_W-1:0]         m_position_reg, m_position_next;

    logic [XW-1:0]            count_ext;
    logic [XW-1:0]            depth_ext;
    logic [XW-1:0]            n_sat;
    logic signed [IW-1:0]     n_idx;
    logic                     load_in_range;
    logic                     ram_we;
    logic [AW-1:0]            ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;
    logic signed [DW-1:0]     key_ext;
    logic signed [DW-1:0]     entry_ext;
    logic signed [DW-1:0]     diff;
    logic signed [IW-1:0]     diff_idx;
    logic signed [IW-1:0]     mid_calc;
    logic signed [IW-1:0]     lo_up;
    logic signed [IW-1:0]     hi_dn;
    logic signed [IW-1:0]     span_up;
    logic signed [IW-1:0]     span_dn;
    logic                     accept;

    // The count register may exceed the table; the search then covers the whole table.
    assign count_ext = XW'(entry_count_reg);
    assign depth_ext = XW'(TABLE_DEPTH);
    assign n_sat     = (count_ext > depth_ext) ? depth_ext : count_ext;
    assign n_idx     = $signed(IW'(n_sat));

    assign load_in_range = XW'(s_entry_index) < depth_ext;
    assign s_ready       = (state_reg == S_IDLE);
    assign accept        = s_valid && s_ready;
    assign ram_we        = accept && (s_mode == MODE_LOAD) && load_in_range;

    always_comb begin
        unique case (state_reg)
            S_PRE_LAST: ram_rd_addr = hi_reg[AW-1:0];
            S_PROBE:    ram_rd_addr = mid_calc[AW-1:0];
            default:    ram_rd_addr = '0;
        endcase
    end

    psts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(s_entry_index)),
        .wr_data (s_value),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The one shared subtractor: key minus the entry just read.
    assign key_ext   = DW'(key_reg);
    assign entry_ext = DW'($signed(ram_rd_data));
    assign diff      = key_ext - entry_ext;
    assign diff_idx  = $signed(diff[IW-1:0]);

    assign mid_calc = (lo_reg + hi_reg) >>> 1;
    assign lo_up    = mid_reg + IDX_ONE;
    assign hi_dn    = mid_reg - IDX_ONE;
    assign span_up  = hi_reg - lo_up;
    assign span_dn  = hi_dn - lo_reg;

    always_comb begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        precheck_next    = precheck_reg;
        gap_prune_next   = gap_prune_reg;
        key_next         = key_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        pend_en_next     = pend_en_reg;
        pend_hi_next     = pend_hi_reg;
        res_found_next   = res_found_reg;
        res_pos_next     = res_pos_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_found_next     = m_found_reg;
        m_position_next  = m_position_reg;

        if (cfg_wen) begin
            unique case (cfg_index)
                CFG_ENTRY_COUNT:    entry_count_next = cfg_wdata[COUNT_W-1:0];
                CFG_BOUNDARY_CHECK: precheck_next    = cfg_wdata[0];
                CFG_GAP_PRUNING:    gap_prune_next   = cfg_wdata[0];
                default:            ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_mode == MODE_SEARCH)) begin
                    key_next     = s_value;
                    lo_next      = '0;
                    hi_next      = n_idx - IDX_ONE;
                    pend_en_next = 1'b0;
                    if (n_sat == '0) begin
                        res_found_next = 1'b0;
                        res_pos_next   = '0;
                        state_next     = S_DONE;
                    end else if (precheck_reg) begin
                        state_next = S_PRE_FIRST;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PRE_FIRST: begin
                state_next = S_PRE_LAST;
            end
            S_PRE_LAST: begin
                // Read data is the first entry; the last entry's read is issued now.
                if (diff <= 0) begin
                    res_found_next = (diff == 0);
                    res_pos_next   = '0;
                    state_next     = S_DONE;
                end else begin
                    pend_en_next = diff < DW'(hi_reg);
                    pend_hi_next = diff_idx;
                    state_next   = S_PRE_NARROW;
                end
            end
            S_PRE_NARROW: begin
                if (diff >= 0) begin
                    res_found_next = (diff == 0);
                    res_pos_next   = (diff == 0) ? hi_reg : hi_reg + IDX_ONE;
                    state_next     = S_DONE;
                end else begin
                    // With lo at zero the span equals hi.
                    if (pend_en_reg) begin
                        hi_next = pend_hi_reg;
                    end
                    if (diff > -DW'(hi_reg)) begin
                        lo_next = hi_reg + diff_idx;
                    end
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (lo_reg > hi_reg) begin
                    res_found_next = 1'b0;
                    res_pos_next   = lo_reg;
                    state_next     = S_DONE;
                end else begin
                    mid_next   = mid_calc;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE: begin
                priority if (diff == 0) begin
                    res_found_next = 1'b1;
                    res_pos_next   = mid_reg;
                    state_next     = S_DONE;
                end else if (diff > 0) begin
                    lo_next = lo_up;
                    if (gap_prune_reg && (diff < DW'(span_up))) begin
                        hi_next = lo_up + diff_idx;
                    end
                    state_next = S_PROBE;
                end else begin
                    hi_next = hi_dn;
                    if (gap_prune_reg && (diff > -DW'(span_dn))) begin
                        lo_next = hi_dn + diff_idx;
                    end
                    state_next = S_PROBE;
                end
            end
            S_DONE: begin
                // Hold the answer until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_found_next    = res_found_reg;
                    m_position_next = POS_W'($unsigned(res_pos_reg));
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            entry_count_reg <= ENTRY_COUNT_RESET;
            precheck_reg    <= 1'b0;
            gap_prune_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            precheck_reg    <= precheck_next;
            gap_prune_reg   <= gap_prune_next;
            m_valid_reg     <= m_valid_next;
        end
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pend_en_reg    <= pend_en_next;
        pend_hi_reg    <= pend_hi_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        m_found_reg    <= m_found_next;
        m_position_reg <= m_position_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

`ifndef SYNTH
    // Every probe address lies within the live search range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COMPARE) |-> (mid_reg >= lo_reg && mid_reg <= hi_reg))
        else $error("probe outside the search range");

    // An answer never points past the end of the searched entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> (res_pos_reg >= 0 && res_pos_reg <= n_idx))
        else $error("result position beyond the searched entries");

    // A match always names an existing entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_found_reg) |-> (res_pos_reg < n_idx))
        else $error("match position beyond the last entry");

    // A load item starts no search.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_LOAD) |=> (state_reg == S_IDLE))
        else $error("load item left the idle state");
`endif

endmodule

// ===== hw/rtl/psts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module psts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
